>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the endpoint projection block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pelu_pkg.sv
// ----------------------------------------------------------------------------
// Endpoint projection package
// Widths, register indexes and payload types of the endpoint projection block.
// ----------------------------------------------------------------------------
package pelu_pkg;

    localparam int COORD_W   = 32;
    localparam int INDEX_W   = 16;
    localparam int UNIT_W    = 18;
    localparam int LEN_W     = COORD_W + 1;
    localparam int EPS_W     = 31;
    localparam int DIST_W    = 32;
    localparam int FRAC      = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_END_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_END_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON      = 3'd4;

    typedef struct packed {
        logic                      elem_present;
        logic [INDEX_W-1:0]        elem_index;
        logic signed [COORD_W-1:0] elem_start_x;
        logic signed [COORD_W-1:0] elem_start_y;
        logic signed [COORD_W-1:0] elem_end_x;
        logic signed [COORD_W-1:0] elem_end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
        logic [INDEX_W-1:0]        source_index;
        logic [DIST_W-1:0]         extension_distance;
        logic                      at_start;
        logic                      last_of_run;
    } t_out_item;

    typedef struct packed {
        logic                     busy;
        logic [LEN_W-1:0]         length;
        logic signed [UNIT_W-1:0] unit_x;
        logic signed [UNIT_W-1:0] unit_y;
    } t_line_geom;

endpackage

>>> src/pelu_round.sv
// ----------------------------------------------------------------------------
// Fixed-point rounding
// Divides a signed value by 2^16, rounding halves away from zero.
// ----------------------------------------------------------------------------
module pelu_round #(
    parameter int IW = 52
) (
    input  logic signed [IW-1:0]                  i_val,
    output logic signed [IW-pelu_pkg::FRAC+1:0]   o_val
);

    localparam int OW = IW - pelu_pkg::FRAC + 2;

    logic          neg;
    logic [IW-1:0] mag;
    logic [IW:0]   sum;
    logic [OW-1:0] sh;

    always_comb begin
        neg   = i_val[IW-1];
        mag   = neg ? IW'(-i_val) : IW'(i_val);
        sum   = {1'b0, mag} + (IW+1)'(1 << (pelu_pkg::FRAC - 1));
        sh    = {1'b0, sum[IW:pelu_pkg::FRAC]};
        o_val = neg ? $signed(OW'(0) - sh) : $signed(sh);
    end

endmodule

>>> src/pelu_setup.sv
// ----------------------------------------------------------------------------
// Line setup sequencer
// Derives length and unit direction of the reference line with a shift-add
// squarer, a digit-by-digit square root and a restoring divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pelu_setup (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_go,
    input  logic signed [pelu_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [pelu_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [pelu_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [pelu_pkg::COORD_W-1:0] i_end_y,
    output pelu_pkg::t_line_geom                o_geom
);

    localparam int LW    = pelu_pkg::LEN_W;
    localparam int UW    = pelu_pkg::UNIT_W;
    localparam int AW    = 2 * LW;
    localparam int RW    = LW + 1;
    localparam int NW    = pelu_pkg::COORD_W + pelu_pkg::FRAC + 2;
    localparam int CNT_W = $clog2(NW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQX  = 3'd1;
    localparam logic [2:0] ST_SQY  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_DIVX = 3'd4;
    localparam logic [2:0] ST_DIVY = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [LW-1:0]        r_mx, n_mx, r_my, n_my;
    logic                 r_sx, n_sx, r_sy, n_sy;
    logic [AW-1:0]        r_ma, n_ma, r_acc, n_acc;
    logic [LW-1:0]        r_mb, n_mb;
    logic [RW-1:0]        r_rem, n_rem;
    logic [LW-1:0]        r_root, n_root;
    logic [NW-1:0]        r_num, n_num;
    logic [LW-1:0]        r_drem, n_drem;
    logic [UW-1:0]        r_q, n_q;
    logic [LW-1:0]        r_len, n_len;
    logic signed [UW-1:0] r_ux, n_ux, r_uy, n_uy;

    logic signed [LW-1:0] dx, dy;
    logic [LW-1:0]        adx, ady;
    logic [AW-1:0]        mac;
    logic [RW+1:0]        rem_sh, trial;
    logic                 sq_ge;
    logic [LW-1:0]        root_nx;
    logic [LW:0]          d_sh;
    logic                 d_ge;
    logic [UW-1:0]        q_nx;

    always_comb begin
        dx      = LW'(i_end_x) - LW'(i_start_x);
        dy      = LW'(i_end_y) - LW'(i_start_y);
        adx     = dx[LW-1] ? LW'(-dx) : LW'(dx);
        ady     = dy[LW-1] ? LW'(-dy) : LW'(dy);
        mac     = r_acc + (r_mb[0] ? r_ma : '0);
        rem_sh  = {r_rem, r_acc[AW-1:AW-2]};
        trial   = {1'b0, r_root, 2'b01};
        sq_ge   = rem_sh >= trial;
        root_nx = {r_root[LW-2:0], sq_ge};
        d_sh    = {r_drem, r_num[NW-1]};
        d_ge    = d_sh >= {1'b0, r_len};
        q_nx    = {r_q[UW-2:0], d_ge};

        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        n_mx    = r_mx;
        n_my    = r_my;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_root  = r_root;
        n_num   = r_num;
        n_drem  = r_drem;
        n_q     = r_q;
        n_len   = r_len;
        n_ux    = r_ux;
        n_uy    = r_uy;

        if (i_go) begin
            n_state = ST_SQX;
            n_cnt   = '0;
            n_mx    = adx;
            n_my    = ady;
            n_sx    = dx[LW-1];
            n_sy    = dy[LW-1];
            n_ma    = AW'(adx);
            n_mb    = adx;
            n_acc   = '0;
        end else begin
            unique case (r_state)
                ST_SQX, ST_SQY: begin
                    n_acc = mac;
                    n_ma  = {r_ma[AW-2:0], 1'b0};
                    n_mb  = {1'b0, r_mb[LW-1:1]};
                    if (r_cnt == CNT_W'(LW - 1)) begin
                        n_cnt = '0;
                        if (r_state == ST_SQX) begin
                            n_state = ST_SQY;
                            n_ma    = AW'(r_my);
                            n_mb    = r_my;
                        end else begin
                            n_state = ST_SQRT;
                            n_rem   = '0;
                            n_root  = '0;
                        end
                    end
                end
                ST_SQRT: begin
                    n_rem  = sq_ge ? RW'(rem_sh - trial) : RW'(rem_sh);
                    n_root = root_nx;
                    n_acc  = {r_acc[AW-3:0], 2'b00};
                    if (r_cnt == CNT_W'(LW - 1)) begin
                        n_cnt  = '0;
                        n_len  = root_nx;
                        n_drem = '0;
                        n_q    = '0;
                        n_num  = (NW'(r_mx) << pelu_pkg::FRAC) + NW'(root_nx >> 1);
                        if (root_nx == '0) begin
                            n_state = ST_IDLE;
                            n_ux    = '0;
                            n_uy    = '0;
                        end else begin
                            n_state = ST_DIVX;
                        end
                    end
                end
                ST_DIVX, ST_DIVY: begin
                    n_drem = d_ge ? LW'(d_sh - {1'b0, r_len}) : d_sh[LW-1:0];
                    n_q    = q_nx;
                    n_num  = {r_num[NW-2:0], 1'b0};
                    if (r_cnt == CNT_W'(NW - 1)) begin
                        n_cnt  = '0;
                        n_drem = '0;
                        n_q    = '0;
                        if (r_state == ST_DIVX) begin
                            n_state = ST_DIVY;
                            n_ux    = r_sx ? $signed(UW'(0) - q_nx) : $signed(q_nx);
                            n_num   = (NW'(r_my) << pelu_pkg::FRAC) + NW'(r_len >> 1);
                        end else begin
                            n_state = ST_IDLE;
                            n_uy    = r_sy ? $signed(UW'(0) - q_nx) : $signed(q_nx);
                        end
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len   <= '0;
            r_ux    <= '0;
            r_uy    <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_ux    <= n_ux;
            r_uy    <= n_uy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_num  <= n_num;
        r_drem <= n_drem;
        r_q    <= n_q;
    end

    always_comb begin
        o_geom.busy   = r_state != ST_IDLE;
        o_geom.length = r_len;
        o_geom.unit_x = r_ux;
        o_geom.unit_y = r_uy;
    end

    `ASSERT_IMPLY(a_div_len_nonzero, i_clk, i_rst_n, (r_state == ST_DIVX) || (r_state == ST_DIVY), r_len != '0)
    `ASSERT_NEXT(a_go_restarts, i_clk, i_rst_n, i_go, r_state == ST_SQX)

endmodule

>>> src/project_endpoints_onto_line_unit.sv
// ----------------------------------------------------------------------------
// Endpoint projection unit
// Projects both endpoints of each element onto a configured reference line.
//
//   Channel  Direction  Handshake                   Payload
//   in       input      i_in_valid / o_in_ready     t_in_item
//   out      output     o_out_valid / i_out_ready   t_out_item
//   cfg      input      i_cfg_we                    i_cfg_index, i_cfg_data
//
// An element passes registers r1 to r7 from transfer to its first result;
// one element enters per cycle while o_in_ready is high, and an element with
// two results holds the output stage until both are taken. A write to a line
// register starts the setup sequencer, which keeps o_in_ready low while it
// runs (a launch register, two 33-step squarings, a 33-step root and two
// 50-step divisions). Stalls hold each stage; empty stages still fill.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module project_endpoints_onto_line_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pelu_pkg::t_in_item                   i_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pelu_pkg::t_out_item                  o_out,
    input  logic                                 i_cfg_we,
    input  logic [pelu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pelu_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int CW   = pelu_pkg::COORD_W;
    localparam int IXW  = pelu_pkg::INDEX_W;
    localparam int UW   = pelu_pkg::UNIT_W;
    localparam int LW   = pelu_pkg::LEN_W;
    localparam int EW   = pelu_pkg::EPS_W;
    localparam int DW   = pelu_pkg::DIST_W;
    localparam int VW   = CW + 1;
    localparam int PW   = VW + UW;
    localparam int SW   = PW + 1;
    localparam int TW   = SW - pelu_pkg::FRAC + 2;
    localparam int MW   = TW + UW;
    localparam int RW   = MW - pelu_pkg::FRAC + 2;
    localparam int PSW  = RW + 1;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [PSW-1:0] v);
        if (v > PSW'(CMAX)) begin
            return CMAX;
        end else if (v < PSW'(CMIN)) begin
            return CMIN;
        end else begin
            return v[CW-1:0];
        end
    endfunction

    logic signed [CW-1:0] r_sx, r_sy, r_ex, r_ey;
    logic [EW-1:0]        r_eps;
    logic                 r_go;
    pelu_pkg::t_line_geom w_geom;
    logic                 w_busy, w_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_sy  <= '0;
            r_ex  <= '0;
            r_ey  <= '0;
            r_eps <= EW'(1);
            r_go  <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pelu_pkg::REG_LINE_START_X: begin
                        r_sx <= i_cfg_data[CW-1:0];
                        r_go <= 1'b1;
                    end
                    pelu_pkg::REG_LINE_START_Y: begin
                        r_sy <= i_cfg_data[CW-1:0];
                        r_go <= 1'b1;
                    end
                    pelu_pkg::REG_LINE_END_X: begin
                        r_ex <= i_cfg_data[CW-1:0];
                        r_go <= 1'b1;
                    end
                    pelu_pkg::REG_LINE_END_Y: begin
                        r_ey <= i_cfg_data[CW-1:0];
                        r_go <= 1'b1;
                    end
                    pelu_pkg::REG_EPSILON: begin
                        r_eps <= i_cfg_data[EW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    pelu_setup u_setup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (r_go),
        .i_start_x (r_sx),
        .i_start_y (r_sy),
        .i_end_x   (r_ex),
        .i_end_y   (r_ey),
        .o_geom    (w_geom)
    );

    assign w_busy  = r_go || w_geom.busy;
    assign w_degen = (w_geom.length == '0) || (w_geom.length < LW'(r_eps));

    // Lane 0 carries the start point, lane 1 the end point.
    logic                  r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic [IXW-1:0]        r1_idx, r2_idx, r3_idx, r4_idx, r5_idx, r6_idx, r7_idx;
    logic signed [VW-1:0]  r1_vx [2], r1_vy [2];
    logic signed [PW-1:0]  r2_px [2], r2_py [2];
    logic signed [SW-1:0]  r3_s [2];
    logic signed [TW-1:0]  r4_t [2];
    logic signed [TW-1:0]  w_t [2];
    logic signed [MW-1:0]  r5_mx [2], r5_my [2];
    logic signed [RW-1:0]  w_rx [2], w_ry [2];
    logic signed [RW-1:0]  r6_rx [2], r6_ry [2];
    logic                  r5_ok [2], r6_ok [2];
    logic [DW-1:0]         r5_dist [2], r6_dist [2], r7_dist [2];
    logic signed [CW-1:0]  r7_x [2], r7_y [2];
    logic [1:0]            r7_pend;

    logic signed [CW-1:0]  w_px [2], w_py [2];
    logic signed [TW:0]    w_dv [2];
    logic [TW:0]           w_dm [2];
    logic                  w_ok [2];
    logic [DW-1:0]         w_dist [2];

    logic en1, en2, en3, en4, en5, en6, en7;
    logic in_take, out_take, w_sel;

    assign out_take = o_out_valid && i_out_ready;
    assign en7 = (r7_pend == 2'b00) || (out_take && (r7_pend != 2'b11));
    assign en6 = !r6_v || en7;
    assign en5 = !r5_v || en6;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign o_in_ready = en1 && !w_busy;
    assign in_take    = i_in_valid && o_in_ready;

    always_comb begin
        w_px[0] = i_in.elem_start_x;
        w_py[0] = i_in.elem_start_y;
        w_px[1] = i_in.elem_end_x;
        w_py[1] = i_in.elem_end_y;
        for (int k = 0; k < 2; k++) begin
            w_dv[k] = (k == 0) ? (TW+1)'(r4_t[k])
                               : (TW+1)'(r4_t[k]) - $signed((TW+1)'(w_geom.length));
            w_dm[k]   = w_dv[k][TW] ? (TW+1)'(-w_dv[k]) : (TW+1)'(w_dv[k]);
            w_ok[k]   = w_dm[k] > (TW+1)'(r_eps);
            w_dist[k] = (w_dm[k][TW:DW] != '0) ? '1 : w_dm[k][DW-1:0];
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_lane
        pelu_round #(.IW(SW)) u_rnd_t (.i_val(r3_s[g]),  .o_val(w_t[g]));
        pelu_round #(.IW(MW)) u_rnd_x (.i_val(r5_mx[g]), .o_val(w_rx[g]));
        pelu_round #(.IW(MW)) u_rnd_y (.i_val(r5_my[g]), .o_val(w_ry[g]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_pend <= 2'b00;
        end else begin
            if (en1) r1_v <= in_take && i_in.elem_present && !w_degen;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
            if (en6) r6_v <= r5_v;
            if (en7) begin
                r7_pend <= {r6_v && r6_ok[1], r6_v && r6_ok[0]};
            end else if (out_take) begin
                r7_pend[0] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            if (en1) begin
                r1_vx[k] <= VW'(w_px[k]) - VW'(r_sx);
                r1_vy[k] <= VW'(w_py[k]) - VW'(r_sy);
            end
            if (en2) begin
                r2_px[k] <= PW'(r1_vx[k]) * PW'(w_geom.unit_x);
                r2_py[k] <= PW'(r1_vy[k]) * PW'(w_geom.unit_y);
            end
            if (en3) r3_s[k] <= SW'(r2_px[k]) + SW'(r2_py[k]);
            if (en4) r4_t[k] <= w_t[k];
            if (en5) begin
                r5_mx[k]   <= MW'(r4_t[k]) * MW'(w_geom.unit_x);
                r5_my[k]   <= MW'(r4_t[k]) * MW'(w_geom.unit_y);
                r5_ok[k]   <= w_ok[k];
                r5_dist[k] <= w_dist[k];
            end
            if (en6) begin
                r6_rx[k]   <= w_rx[k];
                r6_ry[k]   <= w_ry[k];
                r6_ok[k]   <= r5_ok[k];
                r6_dist[k] <= r5_dist[k];
            end
            if (en7) begin
                r7_x[k]    <= sat_coord(PSW'(r_sx) + PSW'(r6_rx[k]));
                r7_y[k]    <= sat_coord(PSW'(r_sy) + PSW'(r6_ry[k]));
                r7_dist[k] <= r6_dist[k];
            end
        end
        if (en1) r1_idx <= i_in.elem_index;
        if (en2) r2_idx <= r1_idx;
        if (en3) r3_idx <= r2_idx;
        if (en4) r4_idx <= r3_idx;
        if (en5) r5_idx <= r4_idx;
        if (en6) r6_idx <= r5_idx;
        if (en7) r7_idx <= r6_idx;
    end

    always_comb begin
        w_sel                    = !r7_pend[0];
        o_out_valid              = r7_pend != 2'b00;
        o_out.proj_x             = r7_x[w_sel];
        o_out.proj_y             = r7_y[w_sel];
        o_out.source_index       = r7_idx;
        o_out.extension_distance = r7_dist[w_sel];
        o_out.at_start           = r7_pend[0];
        o_out.last_of_run        = r7_pend != 2'b11;
    end

    `ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, out_take && o_out.at_start && !o_out.last_of_run, o_out_valid && !o_out.at_start && o_out.last_of_run)
    `ASSERT_NEXT(a_setup_blocks_input, i_clk, i_rst_n, i_cfg_we && (i_cfg_index == pelu_pkg::REG_LINE_END_X), !o_in_ready)

endmodule
